// ----- rtl/tpt_pkg.sv -----
package tpt_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned RidW   = 16;
  localparam int unsigned LenW   = 10;
  localparam int unsigned PidW   = 16;
  localparam int unsigned VtypeW = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned TypeW  = 2;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CntW   = 5;
  localparam int unsigned AddrW  = 3;

  localparam logic [AddrW-1:0] ADDR_ACTIVE = 3'd0;

  localparam logic [CmdW-1:0] CMD_DEFINE = 2'd0;
  localparam logic [CmdW-1:0] CMD_GET    = 2'd1;
  localparam logic [CmdW-1:0] CMD_SET    = 2'd2;

  localparam logic [TypeW-1:0] TYPE_F32  = 2'd0;
  localparam logic [TypeW-1:0] TYPE_I32  = 2'd1;
  localparam logic [TypeW-1:0] TYPE_U32  = 2'd2;
  localparam logic [TypeW-1:0] TYPE_BOOL = 2'd3;

  localparam logic [KindW-1:0] KIND_VALUE = 2'd0;
  localparam logic [KindW-1:0] KIND_ACK   = 2'd1;
  localparam logic [KindW-1:0] KIND_NACK  = 2'd2;

  localparam logic [ErrW-1:0] ERR_UNKNOWN  = 3'd0;
  localparam logic [ErrW-1:0] ERR_READONLY = 3'd1;
  localparam logic [ErrW-1:0] ERR_TYPE     = 3'd2;
  localparam logic [ErrW-1:0] ERR_INVALID  = 3'd3;
  localparam logic [ErrW-1:0] ERR_RANGE    = 3'd4;

  localparam logic [LenW-1:0] GetMinLen  = 10'd2;
  localparam logic [LenW-1:0] SetMinLen  = 10'd3;
  localparam logic [LenW-1:0] BoolNeedLen = 10'd4;
  localparam logic [LenW-1:0] WordNeedLen = 10'd7;

  // one slot's contents
  typedef struct packed {
    logic [PidW-1:0]  id;
    logic [TypeW-1:0] vtype;
    logic             writable;
    logic             has_lower;
    logic             has_upper;
    logic [WordW-1:0] lower;
    logic [WordW-1:0] upper;
    logic [WordW-1:0] value;
  } entry_t;

  // token travelling down the chain during a search
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [PidW-1:0]  pid;
    entry_t           hit;
  } probe_t;

  // a <  b under the given type
  function automatic logic typed_less(logic [TypeW-1:0] t, logic [WordW-1:0] a,
                                      logic [WordW-1:0] b);
    logic a_zero, b_zero, a_nan, b_nan, res;
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != '0);
    if (t == TYPE_F32) begin
      if (a_nan || b_nan || (a_zero && b_zero)) res = 1'b0;
      else if (a[31] != b[31]) res = a[31];
      else if (a[31]) res = a[30:0] > b[30:0];
      else res = a[30:0] < b[30:0];
    end else if (t == TYPE_I32) begin
      res = {~a[31], a[30:0]} < {~b[31], b[30:0]};
    end else begin
      res = a < b;
    end
    return res;
  endfunction

endpackage

// ----- rtl/tpt_cell.sv -----
module tpt_cell
  import tpt_pkg::*;
#(
  parameter int unsigned Index = 0,
  parameter int unsigned IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  logic [IdxW-1:0] wr_slot_i,
  input  entry_t          wr_entry_i,
  input  logic            wr_value_i,
  input  logic [WordW-1:0] value_i,
  input  logic            active_i,
  input  probe_t          probe_i,
  output probe_t          probe_o
);

  entry_t          entry_q;
  entry_t          carry_q;
  logic [PidW-1:0] pid_q;
  logic            valid_q, found_q, hit_q;
  logic            match;

  always_ff @(posedge clk_i) begin
    if (wr_i && wr_slot_i == IdxW'(Index)) begin
      entry_q.id        <= wr_entry_i.id;
      entry_q.vtype     <= wr_entry_i.vtype;
      entry_q.writable  <= wr_entry_i.writable;
      entry_q.has_lower <= wr_entry_i.has_lower;
      entry_q.has_upper <= wr_entry_i.has_upper;
      entry_q.lower     <= wr_entry_i.lower;
      entry_q.upper     <= wr_entry_i.upper;
    end
    // the cell that matched the last search takes the stored value
    if (wr_value_i && hit_q) begin
      entry_q.value <= value_i;
    end
  end

  assign match = probe_i.valid && !probe_i.found && active_i && entry_q.id == probe_i.pid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= probe_i.valid;
      found_q <= probe_i.found || match;
      if (probe_i.valid) hit_q <= match;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q   <= probe_i.pid;
    carry_q <= match ? entry_q : probe_i.hit;
  end

  assign probe_o = '{valid: valid_q, found: found_q, pid: pid_q, hit: carry_q};

endmodule

// ----- rtl/tpt_check.sv -----
module tpt_check
  import tpt_pkg::*;
(
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [LenW-1:0]   len_i,
  input  logic [VtypeW-1:0] vtype_i,
  input  logic [WordW-1:0]  vbits_i,
  input  probe_t            probe_i,
  output logic              emit_o,
  output logic              store_o,
  output logic [KindW-1:0]  kind_o,
  output logic [TypeW-1:0]  type_o,
  output logic [WordW-1:0]  value_o,
  output logic [ErrW-1:0]   err_o
);

  entry_t           e;
  logic [WordW-1:0] v;
  logic             is_bool, low_bad, up_bad;

  assign e       = probe_i.hit;
  assign is_bool = e.vtype == TYPE_BOOL;
  assign v       = is_bool ? {24'd0, vbits_i[7:0]} : vbits_i;
  assign low_bad = e.has_lower && typed_less(e.vtype, v, e.lower);
  assign up_bad  = e.has_upper && typed_less(e.vtype, e.upper, v);

  always_comb begin
    emit_o  = 1'b0;
    store_o = 1'b0;
    kind_o  = KIND_NACK;
    type_o  = '0;
    value_o = '0;
    err_o   = ERR_UNKNOWN;
    if (cmd_i == CMD_GET && len_i >= GetMinLen) begin
      emit_o = 1'b1;
      if (probe_i.found) begin
        kind_o  = KIND_VALUE;
        type_o  = e.vtype;
        value_o = e.value;
      end
    end else if (cmd_i == CMD_SET && len_i >= SetMinLen) begin
      emit_o = 1'b1;
      if (!probe_i.found) err_o = ERR_UNKNOWN;
      else if (!e.writable) err_o = ERR_READONLY;
      else if (vtype_i != VtypeW'(e.vtype)) err_o = ERR_TYPE;
      else if (len_i < (is_bool ? BoolNeedLen : WordNeedLen)) err_o = ERR_INVALID;
      else if (is_bool && vbits_i[7:1] != '0) err_o = ERR_INVALID;
      else if (e.vtype == TYPE_F32 && v[30:23] == 8'hff) err_o = ERR_INVALID;
      else if (!is_bool && (low_bad || up_bad)) err_o = ERR_RANGE;
      else begin
        store_o = 1'b1;
        kind_o  = KIND_ACK;
        type_o  = e.vtype;
        value_o = v;
      end
    end
  end

endmodule

// ----- rtl/typed_parameter_table_get_set.sv -----
// typed parameter table, get and set requests
// input stream s_axis_*: one request item per handshake; tuser carries the
// command (define, get or set), tdata the request fields.
// output stream m_axis_*: zero or one reply item per request; tuser carries
// the reply kind.
// apb port: register 0 at address 0 is active_entries (slots searched).
// a get or set travels as a token down a chain of TABLE_SLOTS cells, one
// cell per cycle; the first active cell with the id latches its entry.
// one item is in flight at a time: after a get or set the next item is
// accepted once its token has left the chain and its reply is taken; a
// dropped request frees the input once its token has left the chain. a
// define item writes its slot in the accept cycle, so defines go one per
// cycle while no search or reply is pending, and give no reply.
// reset clears control state and active_entries; table contents stay
// undefined until defined.
// when the receiver stalls the reply is held in the output register and
// no new item is accepted until it is taken.
module typed_parameter_table_get_set
  import tpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd
  input  logic [1:0]   s_axis_tuser,
  // request tag, byte count, slot, parameter id, value type, value bits,
  // writable, has lower, has upper, lower bound, upper bound; 7 pad bits
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // reply kind
  output logic [1:0]   m_axis_tuser,
  // reply tag, reply id, reply type, reply value, error code; 3 pad bits
  output logic [71:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned SlotW = 4;

  logic [CmdW-1:0]   in_cmd;
  logic [RidW-1:0]   in_rid;
  logic [LenW-1:0]   in_len;
  logic [SlotW-1:0]  in_slot;
  logic [PidW-1:0]   in_pid;
  logic [VtypeW-1:0] in_vtype;
  logic [WordW-1:0]  in_vbits;
  entry_t            def_entry;

  assign in_cmd   = s_axis_tuser;
  assign in_rid   = s_axis_tdata[15:0];
  assign in_len   = s_axis_tdata[25:16];
  assign in_slot  = s_axis_tdata[29:26];
  assign in_pid   = s_axis_tdata[45:30];
  assign in_vtype = s_axis_tdata[53:46];
  assign in_vbits = s_axis_tdata[85:54];

  assign def_entry.id        = in_pid;
  assign def_entry.vtype     = in_vtype[1:0];
  assign def_entry.writable  = s_axis_tdata[86];
  assign def_entry.has_lower = s_axis_tdata[87];
  assign def_entry.has_upper = s_axis_tdata[88];
  assign def_entry.lower     = s_axis_tdata[120:89];
  assign def_entry.upper     = s_axis_tdata[152:121];
  assign def_entry.value     = '0;

  logic [CntW-1:0] active_q;
  assign pready = 1'b1;
  assign prdata = {27'd0, active_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_q <= '0;
    else if (psel && penable && pwrite && paddr == ADDR_ACTIVE) active_q <= pwdata[CntW-1:0];
  end

  logic             busy_q, busy_d;
  logic [CmdW-1:0]  cmd_q;
  logic [RidW-1:0]  rid_q;
  logic [LenW-1:0]  len_q;
  logic [PidW-1:0]  pid_q;
  logic [VtypeW-1:0] vtype_q;
  logic [WordW-1:0] vbits_q;
  logic             in_fire, def_ok;
  probe_t           chain [TABLE_SLOTS+1];
  logic             done;

  assign s_axis_tready = !busy_q && !m_axis_tvalid;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign def_ok  = in_fire && in_cmd == CMD_DEFINE && 32'(in_slot) < TABLE_SLOTS;

  assign chain[0] = '{valid: in_fire && (in_cmd == CMD_GET || in_cmd == CMD_SET),
                      found: 1'b0, pid: in_pid, hit: def_entry};
  assign done = chain[TABLE_SLOTS].valid;

  logic             store;
  logic             emit;
  logic [KindW-1:0] kind;
  logic [TypeW-1:0] rtype;
  logic [WordW-1:0] rvalue;
  logic [ErrW-1:0]  err;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    tpt_cell #(.Index(g), .IdxW(IdxW)) u_cell (
      .clk_i,
      .rst_ni,
      .wr_i           (def_ok),
      .wr_slot_i      (IdxW'(in_slot)),
      .wr_entry_i     (def_entry),
      .wr_value_i     (store && done),
      .value_i        (rvalue),
      .active_i       (32'(active_q) > g),
      .probe_i        (chain[g]),
      .probe_o        (chain[g+1])
    );
  end

  tpt_check u_check (
    .cmd_i  (cmd_q),
    .len_i  (len_q),
    .vtype_i(vtype_q),
    .vbits_i(vbits_q),
    .probe_i(chain[TABLE_SLOTS]),
    .emit_o (emit),
    .store_o(store),
    .kind_o (kind),
    .type_o (rtype),
    .value_o(rvalue),
    .err_o  (err)
  );

  always_comb begin
    busy_d = busy_q;
    if (chain[0].valid) busy_d = 1'b1;
    else if (done) busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (done && emit) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= in_cmd;
      rid_q   <= in_rid;
      len_q   <= in_len;
      pid_q   <= in_pid;
      vtype_q <= in_vtype;
      vbits_q <= in_vbits;
    end
    if (done && emit) begin
      m_axis_tuser <= kind;
      m_axis_tdata <= {3'b0, err, rvalue, rtype, pid_q, rid_q};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !busy_q)
    else $error("item accepted while search in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q)
    else $error("search token without a pending item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("reply dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && emit) |=> m_axis_tvalid)
    else $error("reply not presented");

endmodule
